/* hdl/r4tw_pkg.sv */
// ============================================================================
// r4tw_pkg
// Shared widths, defaults and datapath types of the radix-4 twiddle pass.
// ============================================================================
package r4tw_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_LEN_DEF      = 4096;
    localparam int TWIDDLE_BITS_DEF = 16;

    // Fixed field widths.
    localparam int IN_W  = 16;  // Q1.15 input sample part
    localparam int DAT_W = 19;  // Q4.15 datapath and result part
    localparam int IDX_W = 10;  // butterfly index
    localparam int LEN_W = 4;   // length_log2 register

    localparam logic [LEN_W-1:0] LEN_RESET = 4'd12;

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 168;

    // Request kinds carried on the input tuser bit.
    typedef enum logic {
        CMD_FWD = 1'b0,
        CMD_INV = 1'b1
    } cmd_t;

    typedef logic signed [DAT_W-1:0] dat_t;

    typedef struct packed {
        dat_t re;
        dat_t im;
    } cplx_t;

    typedef cplx_t [3:0] quad_t;

    // Load strobes of the three stages that a twiddle lane spans.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } lane_ctl_t;

endpackage

/* hdl/r4tw_rom.sv */
// ============================================================================
// r4tw_rom
// Quarter-wave sine ROM with two registered read ports. The table is computed
// at elaboration with a Q60 Taylor series and rounded to TWIDDLE_BITS bits.
// ============================================================================
module r4tw_rom #(
    parameter int MAX_LEN      = r4tw_pkg::MAX_LEN_DEF,
    parameter int TWIDDLE_BITS = r4tw_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [$clog2(MAX_LEN/4+1)-1:0]  addr_a,
    input  logic [$clog2(MAX_LEN/4+1)-1:0]  addr_b,
    output logic [TWIDDLE_BITS-1:0]         data_a,
    output logic [TWIDDLE_BITS-1:0]         data_b
);

    localparam int QUARTER = MAX_LEN / 4;
    localparam longint unsigned PI_HALF_Q60 = 64'h1921FB54442D1846;
    localparam longint unsigned UNITY = 64'd1 << (TWIDDLE_BITS - 1);
    localparam longint unsigned TAYLOR_DIV [1:12] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
          64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

    typedef logic [TWIDDLE_BITS-1:0] entry_t;
    typedef entry_t rom_t [0:QUARTER];

    // Product of two Q60 values, kept in Q60.
    function automatic longint unsigned mul_q60(input longint unsigned a,
                                                input longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic rom_t build_rom();
        rom_t            rom;
        longint unsigned step;
        longint unsigned rem;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        int              t;
        int              n;
        step = PI_HALF_Q60 / QUARTER;
        rem  = PI_HALF_Q60 % QUARTER;
        for (t = 0; t <= QUARTER; t++)
        begin
            x    = step * 64'(t) + (rem * 64'(t)) / QUARTER;
            x2   = mul_q60(x, x);
            term = x;
            sum  = longint'(x);
            for (n = 1; n <= 12; n++)
            begin
                term = mul_q60(term, x2) / TAYLOR_DIV[n];
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            v = (64'(sum) + (64'd1 << (60 - TWIDDLE_BITS))) >> (61 - TWIDDLE_BITS);
            if (v > UNITY)
                v = UNITY;
            rom[t] = v[TWIDDLE_BITS-1:0];
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [TWIDDLE_BITS-1:0] data_a_reg;
    logic [TWIDDLE_BITS-1:0] data_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a_reg <= SINE_ROM[addr_a];
            data_b_reg <= SINE_ROM[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

/* hdl/r4tw_bfly.sv */
// ============================================================================
// r4tw_bfly
// Radix-4 butterfly on four complex values, with a bypass that passes the
// values through unchanged. Sums wrap at the datapath width.
// ============================================================================
module r4tw_bfly (
    input  logic            bypass,
    input  r4tw_pkg::quad_t x,
    output r4tw_pkg::quad_t y
);

    r4tw_pkg::dat_t sr02, si02, dr02, di02;
    r4tw_pkg::dat_t sr13, si13, dr13, di13;
    r4tw_pkg::quad_t bf;

    always_comb
    begin
        sr02 = x[0].re + x[2].re;
        si02 = x[0].im + x[2].im;
        dr02 = x[0].re - x[2].re;
        di02 = x[0].im - x[2].im;
        sr13 = x[1].re + x[3].re;
        si13 = x[1].im + x[3].im;
        dr13 = x[1].re - x[3].re;
        di13 = x[1].im - x[3].im;

        bf[0].re = sr02 + sr13;
        bf[0].im = si02 + si13;
        bf[2].re = sr02 - sr13;
        bf[2].im = si02 - si13;
        // Odd outputs take the difference of the odd pair turned by -i and +i.
        bf[1].re = dr02 + di13;
        bf[1].im = di02 - dr13;
        bf[3].re = dr02 - di13;
        bf[3].im = di02 + dr13;

        y = bypass ? x : bf;
    end

endmodule

/* hdl/r4tw_lane.sv */
// ============================================================================
// r4tw_lane
// One twiddle lane: ROM lookup, twiddle sign selection, complex multiply and
// round-to-nearest, spread over three register stages.
// ============================================================================
module r4tw_lane #(
    parameter int MAX_LEN      = r4tw_pkg::MAX_LEN_DEF,
    parameter int TWIDDLE_BITS = r4tw_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                         clk,
    input  r4tw_pkg::lane_ctl_t          ctl,
    input  logic [$clog2(MAX_LEN)-1:0]   tw_addr,  // table angle, before stage 1
    input  r4tw_pkg::cplx_t              x,        // sample held in stage 1
    output r4tw_pkg::cplx_t              y         // rotated sample, stage 3
);

    localparam int MLOG    = $clog2(MAX_LEN);
    localparam int RW      = MLOG - 2;
    localparam int AW      = MLOG - 1;
    localparam int QUARTER = MAX_LEN / 4;
    localparam int TW_W    = TWIDDLE_BITS + 1;
    localparam int PW      = r4tw_pkg::DAT_W + TW_W;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (TWIDDLE_BITS - 2);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [AW-1:0]            addr_a;
    logic [AW-1:0]            addr_b;
    logic [TWIDDLE_BITS-1:0]  rom_a;
    logic [TWIDDLE_BITS-1:0]  rom_b;
    logic [1:0]               quad_reg;
    logic signed [TW_W-1:0]   mag_a;
    logic signed [TW_W-1:0]   mag_b;
    logic signed [TW_W-1:0]   wr;
    logic signed [TW_W-1:0]   wi;
    logic signed [PW-1:0]     rr_reg, ii_reg, ri_reg, ir_reg;
    logic [PW:0]              sum_re;
    logic [PW:0]              sum_im;
    r4tw_pkg::cplx_t          y_reg;

    // Port A reads sin(r), port B reads sin(quarter - r) = cos(r).
    assign addr_a = {1'b0, tw_addr[RW-1:0]};
    assign addr_b = AW'(QUARTER) - {1'b0, tw_addr[RW-1:0]};

    r4tw_rom #(
        .MAX_LEN      (MAX_LEN),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_rom (
        .clk    (clk),
        .en     (ctl.ld1),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .data_a (rom_a),
        .data_b (rom_b)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
            quad_reg <= tw_addr[MLOG-1 -: 2];
    end

    // Twiddle exp(-i*angle): real part is the cosine, imaginary part the
    // negated sine, both folded out of the first quadrant.
    always_comb
    begin
        mag_a = signed'({1'b0, rom_a});
        mag_b = signed'({1'b0, rom_b});
        unique case (quad_reg)
            QUAD_0:
            begin
                wr = mag_b;
                wi = -mag_a;
            end
            QUAD_1:
            begin
                wr = -mag_a;
                wi = -mag_b;
            end
            QUAD_2:
            begin
                wr = -mag_b;
                wi = mag_a;
            end
            QUAD_3:
            begin
                wr = mag_a;
                wi = mag_b;
            end
            default:
            begin
                wr = mag_b;
                wi = -mag_a;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld2)
        begin
            rr_reg <= x.re * wr;
            ii_reg <= x.im * wi;
            ri_reg <= x.re * wi;
            ir_reg <= x.im * wr;
        end
    end

    // Add half an LSB, then an arithmetic shift; the low bits of the wide
    // sum are exact, so the slice is the rounded result at datapath width.
    assign sum_re = {rr_reg[PW-1], rr_reg} - {ii_reg[PW-1], ii_reg} + HALF;
    assign sum_im = {ri_reg[PW-1], ri_reg} + {ir_reg[PW-1], ir_reg} + HALF;

    always_ff @(posedge clk)
    begin
        if (ctl.ld3)
        begin
            y_reg.re <= sum_re[TWIDDLE_BITS-1 +: r4tw_pkg::DAT_W];
            y_reg.im <= sum_im[TWIDDLE_BITS-1 +: r4tw_pkg::DAT_W];
        end
    end

    assign y = y_reg;

endmodule

/* hdl/radix4_twiddle_pass.sv */
// ============================================================================
// radix4_twiddle_pass
// One radix-4 FFT butterfly with twiddle rotation, for the first (forward) or
// last (inverse) pass of a complex FFT of length N = 2^length_log2. Each
// request carries four Q1.15 complex samples and the butterfly index j, and
// yields one request of four Q4.15 results with j echoed. Forward requests
// run the butterfly and then rotate output k by exp(-2*pi*i*k*j/N); inverse
// requests rotate the samples first, then run the butterfly and negate the
// imaginary parts. The block takes a new request in every cycle while the
// output is not stalled, and has four register stages: the sine ROM read,
// the twiddle multiply, the rounding sum and the output butterfly each own a
// stage. The four stages stall stage by stage, so bubbles are squeezed out
// and the input stays ready while the output waits, as long as an earlier
// stage is empty. The twiddle table holds MAX_LEN/4+1 entries, is fixed at
// build time and needs no start-up pass. MAX_LEN must be a power of two. Write
// length_log2 only while no request is in flight; values below 3 act as 3
// and values above log2(MAX_LEN) act as log2(MAX_LEN).
// ============================================================================
module radix4_twiddle_pass #(
    parameter int MAX_LEN      = r4tw_pkg::MAX_LEN_DEF,
    parameter int TWIDDLE_BITS = r4tw_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration: length_log2.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [r4tw_pkg::LEN_W-1:0]         cfg_data,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // index, in0_re, in0_im, in1_re, in1_im, in2_re, in2_im, in3_re, in3_im,
    // zero pad
    input  logic [r4tw_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // cmd (0 forward, 1 inverse)
    input  logic                               s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_index, out0_re, out0_im, out1_re, out1_im, out2_re, out2_im,
    // out3_re, out3_im, zero pad
    output logic [r4tw_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    localparam int MLOG   = $clog2(MAX_LEN);
    localparam int LENC_W = 5;
    localparam int KJ_W   = r4tw_pkg::IDX_W + 2;
    localparam int IN_W   = r4tw_pkg::IN_W;
    localparam int DAT_W  = r4tw_pkg::DAT_W;
    localparam int IDX_W  = r4tw_pkg::IDX_W;
    localparam int PAD_W  = r4tw_pkg::M_TDATA_W - IDX_W - 8 * DAT_W;

    localparam logic [LENC_W-1:0] LEN_MIN = 5'd3;
    localparam logic [LENC_W-1:0] LEN_MAX = LENC_W'(MLOG);

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    logic [r4tw_pkg::LEN_W-1:0] len_reg;
    logic [LENC_W-1:0]          len_raw;
    logic [LENC_W-1:0]          len_c;
    logic [LENC_W-1:0]          len_shift;
    logic [MLOG-1:0]            len_mask;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= r4tw_pkg::LEN_RESET;
        else if (cfg_valid && cfg_ready)
            len_reg <= cfg_data;
    end

    always_comb
    begin
        len_raw = {1'b0, len_reg};
        priority if (len_raw < LEN_MIN)
            len_c = LEN_MIN;
        else if (len_raw > LEN_MAX)
            len_c = LEN_MAX;
        else
            len_c = len_raw;
        len_shift = LEN_MAX - len_c;
        len_mask  = ~({MLOG{1'b1}} << len_c);
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage loads when it is empty or the stage after
    // it moves on in the same cycle.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    logic ld1, ld2, ld3, ld4;
    r4tw_pkg::lane_ctl_t lane_ctl;

    assign en4 = !v4_reg || m_axis_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign ld1 = en1 && s_axis_tvalid;
    assign ld2 = en2 && v1_reg;
    assign ld3 = en3 && v2_reg;
    assign ld4 = en4 && v3_reg;

    assign lane_ctl.ld1 = ld1;
    assign lane_ctl.ld2 = ld2;
    assign lane_ctl.ld3 = ld3;

    assign s_axis_tready = en1;
    assign m_axis_tvalid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_axis_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input side: unpack, forward butterfly, twiddle angles.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  j_in;
    logic              cmd_in;
    r4tw_pkg::quad_t   x_in;
    r4tw_pkg::quad_t   x_pre;
    logic [KJ_W-1:0]   kj [1:3];
    logic [MLOG-1:0]   tw_addr [1:3];

    assign j_in   = s_axis_tdata[IDX_W-1:0];
    assign cmd_in = s_axis_tuser;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            x_in[k].re = r4tw_pkg::dat_t'(signed'(
                s_axis_tdata[IDX_W + 2*IN_W*k +: IN_W]));
            x_in[k].im = r4tw_pkg::dat_t'(signed'(
                s_axis_tdata[IDX_W + 2*IN_W*k + IN_W +: IN_W]));
        end
    end

    // k*j for k = 1..3, without a multiplier.
    assign kj[1] = {2'b00, j_in};
    assign kj[2] = {1'b0, j_in, 1'b0};
    assign kj[3] = {2'b00, j_in} + {1'b0, j_in, 1'b0};

    // The angle wraps modulo N and is then scaled up to the table's step.
    always_comb
    begin
        for (int k = 1; k < 4; k++)
            tw_addr[k] = ((MLOG)'(kj[k]) & len_mask) << len_shift;
    end

    // Forward requests take the butterfly before rotation.
    r4tw_bfly u_bfly_pre (
        .bypass (cmd_in == r4tw_pkg::CMD_INV),
        .x      (x_in),
        .y      (x_pre)
    );

    // ------------------------------------------------------------------
    // Stage registers for the control fields and the unrotated lane 0.
    // ------------------------------------------------------------------
    logic              cmd1_reg, cmd2_reg, cmd3_reg;
    logic [IDX_W-1:0]  j1_reg, j2_reg, j3_reg, j4_reg;
    r4tw_pkg::quad_t   x1_reg;
    r4tw_pkg::cplx_t   x0_2_reg, x0_3_reg;
    r4tw_pkg::quad_t   y4_reg;

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            cmd1_reg <= cmd_in;
            j1_reg   <= j_in;
            x1_reg   <= x_pre;
        end
        if (ld2)
        begin
            cmd2_reg <= cmd1_reg;
            j2_reg   <= j1_reg;
            x0_2_reg <= x1_reg[0];
        end
        if (ld3)
        begin
            cmd3_reg <= cmd2_reg;
            j3_reg   <= j2_reg;
            x0_3_reg <= x0_2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Twiddle lanes for samples 1..3.
    // ------------------------------------------------------------------
    r4tw_pkg::cplx_t lane_y [1:3];

    for (genvar k = 1; k < 4; k++)
    begin : g_lane
        r4tw_lane #(
            .MAX_LEN      (MAX_LEN),
            .TWIDDLE_BITS (TWIDDLE_BITS)
        ) u_lane (
            .clk     (clk),
            .ctl     (lane_ctl),
            .tw_addr (tw_addr[k]),
            .x       (x1_reg[k]),
            .y       (lane_y[k])
        );
    end

    // ------------------------------------------------------------------
    // Output side: inverse butterfly, conjugate, output register.
    // ------------------------------------------------------------------
    r4tw_pkg::quad_t s3_quad;
    r4tw_pkg::quad_t y_post;
    r4tw_pkg::quad_t y_out;

    assign s3_quad[0] = x0_3_reg;
    assign s3_quad[1] = lane_y[1];
    assign s3_quad[2] = lane_y[2];
    assign s3_quad[3] = lane_y[3];

    r4tw_bfly u_bfly_post (
        .bypass (cmd3_reg == r4tw_pkg::CMD_FWD),
        .x      (s3_quad),
        .y      (y_post)
    );

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            y_out[k].re = y_post[k].re;
            y_out[k].im = (cmd3_reg == r4tw_pkg::CMD_INV) ? -y_post[k].im : y_post[k].im;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            j4_reg <= j3_reg;
            y4_reg <= y_out;
        end
    end

    assign m_axis_tdata = {
        {PAD_W{1'b0}},
        y4_reg[3].im, y4_reg[3].re,
        y4_reg[2].im, y4_reg[2].re,
        y4_reg[1].im, y4_reg[1].re,
        y4_reg[0].im, y4_reg[0].re,
        j4_reg
    };

`ifndef SYNTHESIS
    // A full pipeline facing a stalled output must push back on the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input ready while every stage is full and output stalled");

    // An accepted request always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("accepted request lost before stage 1");

    // A request leaving the last internal stage shows up on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && en4) |=> m_axis_tvalid)
        else $error("request lost between stage 3 and the output register");

    // An output held under stall keeps the same index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !m_axis_tready) |=> (j4_reg == $past(j4_reg)))
        else $error("stalled result changed its index");
`endif

endmodule
